// File: design/fsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_pkg
// shared constants, codes and widths of the flash sub-request queue
// ----------------------------------------------------------------------------
package fsq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 8;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 80;
  localparam int OUT_W    = 88;

  localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd2;
  localparam logic [OP_W-1:0] OP_CONFLICT  = 3'd3;
  localparam logic [OP_W-1:0] OP_TARGET    = 3'd4;
  localparam logic [OP_W-1:0] OP_READ      = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [32:0] loc;
    logic [31:0] lpn;
    logic [7:0]  tag;
  } entry_t;

endpackage

// File: design/fsq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module fsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/flash_subrequest_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_subrequest_queue_unit
// ordered queue of flash sub-requests with remove by tag, read by position
// and in-order conflict and target search through one shared compare unit
// ----------------------------------------------------------------------------
// flow: push, unused code and read past occupancy go from idle straight to
// the result; read, remove and searches pass through a read state and a
// compare state per entry visited, one entry per visit through the single
// ram read port, and a miss ends in one more read state past the last entry
// throughput: one request at a time, next request taken after the result
// is accepted
// reset: queue empty, order list back to identity, no result pending
module flash_subrequest_queue_unit #(
  parameter int QUEUE_DEPTH = fsq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = fsq_pkg::TAG_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // entry_tag, logical_page, channel_id, lun_id, plane_id, block_id,
  // page_id, block_any, page_any, position, zero fill
  input  logic [fsq_pkg::IN_W-1:0]    s_axis_tdata,
  // operation
  input  logic [fsq_pkg::OP_W-1:0]    s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // match_tag, match_page_number, match_channel, match_lun, match_plane,
  // match_block, match_page, match_position, occupancy, empty_flag, zero fill
  output logic [fsq_pkg::OUT_W-1:0]   m_axis_tdata,
  // status
  output logic [fsq_pkg::STATUS_W-1:0] m_axis_tuser
);
  import fsq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TW    = (TAG_BITS < 8) ? TAG_BITS : 8;
  localparam logic [7:0] TAG_MASK = 8'((16'd1 << TW) - 16'd1);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_OUT} state_t;

  state_t state;
  logic [IDX_W-1:0] order [QUEUE_DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [OP_W-1:0]  op;
  entry_t           req;
  logic [2:0]       req_plane_q;
  logic             blk_any, pg_any;
  logic [STATUS_W-1:0] status;
  entry_t           hit_e;
  logic [3:0]       hit_pos;

  entry_t           in_e;
  entry_t           rd_e;
  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;
  logic             hit;
  logic             push_ok;
  logic [IDX_W-1:0] free_slot;
  logic [IDX_W-1:0] cur_slot;

  assign in_e.tag = s_axis_tdata[7:0] & TAG_MASK;
  assign in_e.lpn = s_axis_tdata[39:8];
  assign in_e.loc = {s_axis_tdata[43:40], s_axis_tdata[47:44], s_axis_tdata[50:48],
                     s_axis_tdata[62:51], s_axis_tdata[72:63]};

  assign free_slot = order[count[IDX_W-1:0]];
  assign cur_slot  = order[idx[IDX_W-1:0]];
  assign push_ok   = 32'(count) < 32'(QUEUE_DEPTH);
  assign ram_we    = (state == S_IDLE) && s_axis_tvalid && s_axis_tready &&
                     (s_axis_tuser == OP_PUSH_TAIL || s_axis_tuser == OP_PUSH_HEAD) &&
                     push_ok;
  assign ram_raddr = cur_slot;
  assign req_plane_q = req.loc[24:22];

  fsq_ram #(.WIDTH($bits(entry_t)), .DEPTH(QUEUE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_slot),
    .wdata (in_e),
    .raddr (ram_raddr),
    .rdata (rd_e)
  );

  always_comb begin
    unique case (op)
      OP_REMOVE:   hit = (rd_e.tag == req.tag);
      OP_CONFLICT: hit = (rd_e.tag == req.tag) || (rd_e.lpn == req.lpn) ||
                         (rd_e.loc == req.loc);
      OP_TARGET:   hit = (rd_e.loc[24:22] == req_plane_q) &&
                         (blk_any || rd_e.loc[21:10] == req.loc[21:10]) &&
                         (pg_any || rd_e.loc[9:0] == req.loc[9:0]);
      OP_READ:     hit = 1'b1;
      default:     hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
        order[j] <= IDX_W'(j);
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op      <= s_axis_tuser;
            req     <= in_e;
            blk_any <= s_axis_tdata[73];
            pg_any  <= s_axis_tdata[74];
            hit_e   <= '0;
            hit_pos <= '0;
            if (s_axis_tuser == OP_PUSH_TAIL || s_axis_tuser == OP_PUSH_HEAD) begin
              idx   <= '0;
              state <= S_OUT;
              if (!push_ok) begin
                status <= ST_FULL;
              end else begin
                status <= ST_DONE;
                count  <= count + CNT_W'(1);
                if (s_axis_tuser == OP_PUSH_HEAD) begin
                  for (int j = 1; j < QUEUE_DEPTH; j++) begin
                    if (32'(j) <= 32'(count)) begin
                      order[j] <= order[j-1];
                    end
                  end
                  order[0] <= free_slot;
                end
              end
            end else if (s_axis_tuser == OP_READ &&
                         32'(s_axis_tdata[78:75]) < 32'(count)) begin
              status <= ST_MISS;
              idx    <= CNT_W'(s_axis_tdata[78:75]);
              state  <= S_RD;
            end else if (s_axis_tuser == OP_REMOVE || s_axis_tuser == OP_CONFLICT ||
                         s_axis_tuser == OP_TARGET) begin
              status <= ST_MISS;
              idx    <= '0;
              state  <= S_RD;
            end else begin
              status <= ST_MISS;
              idx    <= '0;
              state  <= S_OUT;
            end
          end
        end
        S_RD: begin
          if (idx >= count) begin
            state <= S_OUT;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            status  <= ST_DONE;
            hit_e   <= rd_e;
            hit_pos <= 4'(idx);
            state   <= S_OUT;
            if (op == OP_REMOVE) begin
              count <= count - CNT_W'(1);
              for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
                if (32'(j) >= 32'(idx) && 32'(j) + 1 < 32'(count)) begin
                  order[j] <= order[j+1];
                end
              end
              order[IDX_W'(count - CNT_W'(1))] <= cur_slot;
            end
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_RD;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tuser  = status;
  assign m_axis_tdata  = {5'd0, (count == '0), 5'(count), hit_pos, hit_e.loc[9:0],
                          hit_e.loc[21:10], hit_e.loc[24:22], hit_e.loc[28:25],
                          hit_e.loc[32:29], hit_e.lpn, hit_e.tag};
endmodule

// File: design/fsq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_checker
// port-level checks of the flash sub-request queue
// ----------------------------------------------------------------------------
module fsq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [fsq_pkg::OUT_W-1:0]    m_axis_tdata,
  input logic [fsq_pkg::STATUS_W-1:0] m_axis_tuser
);
  import fsq_pkg::*;

  // one request in flight: never taking input while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("input taken with result pending");

  // busy after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after a request");

  // empty flag agrees with occupancy
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[82] == (m_axis_tdata[81:77] == 5'd0)))
    else $error("empty flag disagrees with occupancy");

  // miss or full gives zero match fields
  a_zero_miss: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != ST_DONE) |-> (m_axis_tdata[76:0] == '0))
    else $error("match fields set on a miss");

  // result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped before accept");
endmodule

bind flash_subrequest_queue_unit fsq_checker u_fsq_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives random and directed queue requests (pushes, removes, searches,
// reads and unused codes) into the sub-request queue and checks every result
// against a behavioral model of the ordered queue kept in a scoreboard class
// ----------------------------------------------------------------------------
module testbench;
  import fsq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] lpn;
    logic [3:0]  chan;
    logic [3:0]  lun;
    logic [2:0]  plane;
    logic [11:0] blk;
    logic [9:0]  pg;
  } qentry_t;

  localparam int QE_W = $bits(qentry_t);

  typedef struct packed {
    logic [1:0]  status;
    qentry_t     ent;
    logic [3:0]  pos;
    logic [4:0]  occ;
    logic        empty;
  } qresult_t;

  class queue_scoreboard;
    qentry_t  entries[$];
    qresult_t pending[$];
    int       errors;

    function void note_request(logic [2:0] op, qentry_t req, logic bany,
                               logic pany, logic [3:0] rpos);
      qresult_t r;
      int       hit;
      r = '0;
      r.status = ST_MISS;
      hit = -1;
      case (op) inside
        OP_PUSH_TAIL, OP_PUSH_HEAD: begin
          if (entries.size() >= DEPTH) r.status = ST_FULL;
          else begin
            if (op == OP_PUSH_HEAD) entries.push_front(req);
            else entries.push_back(req);
            r.status = ST_DONE;
          end
        end
        OP_REMOVE: begin
          foreach (entries[i])
            if (hit < 0 && entries[i].tag == req.tag) hit = i;
        end
        OP_CONFLICT: begin
          foreach (entries[i])
            if (hit < 0 && (entries[i].tag == req.tag || entries[i].lpn == req.lpn ||
                {entries[i].chan, entries[i].lun, entries[i].plane, entries[i].blk,
                 entries[i].pg} == {req.chan, req.lun, req.plane, req.blk, req.pg}))
              hit = i;
        end
        OP_TARGET: begin
          foreach (entries[i])
            if (hit < 0 && entries[i].plane == req.plane &&
                (bany || entries[i].blk == req.blk) && (pany || entries[i].pg == req.pg))
              hit = i;
        end
        OP_READ: if (int'(rpos) < entries.size()) hit = int'(rpos);
        default: ;
      endcase
      if (hit >= 0) begin
        r.status = ST_DONE;
        r.ent = entries[hit];
        r.pos = hit[3:0];
        if (op == OP_REMOVE) entries.delete(hit);
      end
      r.occ = 5'(entries.size());
      r.empty = entries.size() == 0;
      pending.push_back(r);
    endfunction

    function void report(string name, logic [31:0] e, logic [31:0] a);
      $display("%0t: %s mismatch expected %h actual %h", $time, name, e, a);
      errors++;
    endfunction

    function void check_result(logic [1:0] st, logic [OUT_W-1:0] d);
      qresult_t got, exp;
      got.status = st;
      got.ent.tag = d[7:0];
      got.ent.lpn = d[39:8];
      got.ent.chan = d[43:40];
      got.ent.lun = d[47:44];
      got.ent.plane = d[50:48];
      got.ent.blk = d[62:51];
      got.ent.pg = d[72:63];
      got.pos = d[76:73];
      got.occ = d[81:77];
      got.empty = d[82];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d data=%h", $time, st, d);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        report("status", 32'(exp.status), 32'(got.status));
      if (got.ent.tag !== exp.ent.tag)
        report("match_tag", 32'(exp.ent.tag), 32'(got.ent.tag));
      if (got.ent.lpn !== exp.ent.lpn)
        report("match_page_number", exp.ent.lpn, got.ent.lpn);
      if (got.ent.chan !== exp.ent.chan)
        report("match_channel", 32'(exp.ent.chan), 32'(got.ent.chan));
      if (got.ent.lun !== exp.ent.lun)
        report("match_lun", 32'(exp.ent.lun), 32'(got.ent.lun));
      if (got.ent.plane !== exp.ent.plane)
        report("match_plane", 32'(exp.ent.plane), 32'(got.ent.plane));
      if (got.ent.blk !== exp.ent.blk)
        report("match_block", 32'(exp.ent.blk), 32'(got.ent.blk));
      if (got.ent.pg !== exp.ent.pg)
        report("match_page", 32'(exp.ent.pg), 32'(got.ent.pg));
      if (got.pos !== exp.pos)
        report("match_position", 32'(exp.pos), 32'(got.pos));
      if (got.occ !== exp.occ)
        report("occupancy", 32'(exp.occ), 32'(got.occ));
      if (got.empty !== exp.empty)
        report("empty_flag", 32'(exp.empty), 32'(got.empty));
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic [OP_W-1:0] s_axis_tuser;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;

  queue_scoreboard sb;
  int cycles;
  logic [7:0] tag_pool[4];

  flash_subrequest_queue_unit uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    @(negedge rst);
    forever begin
      @(negedge clk);
      m_axis_tready = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        repeat (gap_len()) @(negedge clk);
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic send(logic [2:0] op, qentry_t e, logic bany, logic pany, logic [3:0] pos);
    s_axis_tdata = {1'b0, pos, pany, bany, e.pg, e.blk, e.plane, e.lun, e.chan, e.lpn, e.tag};
    s_axis_tuser = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(op, e, bany, pany, pos);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    repeat (gap_len()) @(negedge clk);
  endtask

  function automatic qentry_t rand_entry(bit narrow);
    qentry_t e;
    e = QE_W'({$urandom, $urandom, $urandom});
    if (narrow) begin
      e.tag = tag_pool[2'($urandom_range(0, 3))];
      e.lpn = $urandom_range(0, 7);
      e.plane = 3'($urandom_range(0, 1));
      e.blk = 12'($urandom_range(0, 2));
      e.pg = 10'($urandom_range(0, 2));
      e.chan = 4'($urandom_range(0, 1));
      e.lun = 4'($urandom_range(0, 1));
    end
    return e;
  endfunction

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    qentry_t e;
    int r;
    logic [2:0] opc;
    sb = new();
    cycles = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    for (int i = 0; i < 4; i++) tag_pool[i] = 8'($urandom);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty queue, extremes, fill to full, overflow, odd codes
    send(OP_READ, '0, 0, 0, 4'd0);
    send(OP_REMOVE, '0, 0, 0, 4'd0);
    send(OP_CONFLICT, '1, 0, 0, 4'd0);
    send(OP_TARGET, '0, 1, 1, 4'd0);
    send(OP_PUSH_TAIL, '1, 0, 0, 4'd0);
    send(OP_PUSH_HEAD, '0, 0, 0, 4'd0);
    send(OP_PUSH_TAIL, '1, 0, 0, 4'd15);
    send(OP_CONFLICT, '1, 0, 0, 4'd0);
    send(OP_TARGET, '1, 0, 0, 4'd0);
    send(OP_TARGET, '0, 1, 1, 4'd0);
    send(OP_READ, '0, 1, 1, 4'd2);
    send(OP_READ, '0, 0, 0, 4'd3);
    send(OP_UNUSED_LO, '1, 1, 1, 4'd15);
    send(OP_UNUSED_HI, '0, 0, 0, 4'd0);
    for (int i = 0; i < 14; i++) send(OP_PUSH_TAIL, rand_entry(0), 0, 0, 4'd0);
    send(OP_PUSH_HEAD, '1, 0, 0, 4'd0);
    send(OP_READ, '0, 0, 0, 4'd15);
    send(OP_REMOVE, '1, 0, 0, 4'd0);
    drain();

    for (int n = 0; n < 1000; n++) begin
      if (n == 500) drain();
      r = $urandom_range(0, 99);
      e = rand_entry($urandom_range(0, 4) != 0);
      if (r < 30) opc = OP_PUSH_TAIL;
      else if (r < 42) opc = OP_PUSH_HEAD;
      else if (r < 62) opc = OP_REMOVE;
      else if (r < 74) opc = OP_CONFLICT;
      else if (r < 86) opc = OP_TARGET;
      else if (r < 97) opc = OP_READ;
      else if ($urandom_range(0, 1) == 0) opc = OP_UNUSED_LO;
      else opc = OP_UNUSED_HI;
      send(opc, e, 1'($urandom), 1'($urandom), 4'($urandom));
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
